/* sv/rca_pkg.sv */
// ----------------------------------------------------------------------------
// rca_pkg
// Shared constants for the root range check and class set block.
// ----------------------------------------------------------------------------
package rca_pkg;

    localparam int RANGE_ENTRIES_DEF = 256;
    localparam int SET_ENTRIES_DEF   = 2048;

    localparam int ADDR_W   = 64;
    localparam int CNT_W    = 17;
    localparam int CLASS_W  = 11;
    localparam int CFG_IDX_W = 8;

    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;

    localparam logic [CNT_W-1:0] VISIT_LIMIT_RST = 17'd65536;
    localparam logic [CNT_W-1:0] ALERT_THR_RST   = 17'd20000;

    localparam logic [1:0] MODE_CLEAR = 2'd0;
    localparam logic [1:0] MODE_RANGE = 2'd1;
    localparam logic [1:0] MODE_VISIT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_VISIT_LIMIT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALERT_THR   = 8'd1;

endpackage

/* sv/rca_ram.sv */
// ----------------------------------------------------------------------------
// rca_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rca_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sv/root_range_check_and_class_set.sv */
// ----------------------------------------------------------------------------
// root_range_check_and_class_set
// Counts root visits, checks each address against a sorted range table and
// records distinct class words in a linear-probing hash set.
// ----------------------------------------------------------------------------
// Usage: items arrive on the s_ channel (valid/ready), one result per item
// leaves on the m_ channel (valid/ready). cfg_ writes set visit_limit
// (index 0) and alert_threshold (index 1); cfg_ready is always high.
// One item is processed at a time; s_ready is high only in the idle state.
// Clear: resets the counters, plus a sweep of the class RAM when the
// set holds any class. Add range: writes the range RAM. Visit: a read
// and a compare per binary search step through the range RAM (up to
// log2(RANGE_ENTRIES)+1 steps), then FNV-1a over the class word, one byte
// per multiply, then reciprocal-multiply modulo when SET_ENTRIES is not a
// power of two, then a read and a compare per probe of the class RAM,
// then the result load.
// Reset runs a sweep zeroing the class RAM; s_ready stays low until it
// ends. A result waits in the output register while the receiver stalls;
// the next item is accepted meanwhile but its result is held back until
// the register frees.
// ----------------------------------------------------------------------------
module root_range_check_and_class_set #(
    parameter int RANGE_ENTRIES = rca_pkg::RANGE_ENTRIES_DEF,
    parameter int SET_ENTRIES   = rca_pkg::SET_ENTRIES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_mode,
    input  logic [rca_pkg::ADDR_W-1:0]    s_range_start,
    input  logic [rca_pkg::ADDR_W-1:0]    s_range_end,
    input  logic [rca_pkg::ADDR_W-1:0]    s_object_address,
    input  logic [rca_pkg::ADDR_W-1:0]    s_class_word,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [rca_pkg::CNT_W-1:0]     m_total_roots,
    output logic [rca_pkg::CNT_W-1:0]     m_offheap_roots,
    output logic                          m_capped,
    output logic [rca_pkg::CLASS_W-1:0]   m_distinct_classes,
    output logic                          m_item_offheap,
    output logic [1:0]                    m_score,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rca_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rca_pkg::CNT_W-1:0]     cfg_data
);

    localparam int RA_W = $clog2(RANGE_ENTRIES);
    localparam int RC_W = $clog2(RANGE_ENTRIES + 1);
    localparam int SW   = $clog2(SET_ENTRIES);
    localparam int CC_W = $clog2(SET_ENTRIES / 2 + 1);
    localparam bit SET_POW2 = (SET_ENTRIES & (SET_ENTRIES - 1)) == 0;
    localparam int AW = rca_pkg::ADDR_W;
    localparam int CW = rca_pkg::CNT_W;
    localparam logic [63:0] MOD_MAGIC = ((64'd1 << (32 + SW)) / 64'(SET_ENTRIES)) + 64'd1;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_SWEEP = 9'b000000010,
        ST_S_RD  = 9'b000000100,
        ST_S_CMP = 9'b000001000,
        ST_HASH  = 9'b000010000,
        ST_MOD   = 9'b000100000,
        ST_P_RD  = 9'b001000000,
        ST_P_CMP = 9'b010000000,
        ST_DONE  = 9'b100000000
    } state_t;

    state_t                 state_reg, state_next;
    logic [CW-1:0]          limit_reg, limit_next;
    logic [CW-1:0]          thr_reg, thr_next;
    logic [CW-1:0]          root_reg, root_next;
    logic [CW-1:0]          outside_reg, outside_next;
    logic                   cap_reg, cap_next;
    logic [CC_W-1:0]        ccount_reg, ccount_next;
    logic [RC_W-1:0]        rcount_reg, rcount_next;
    logic                   sweep_item_reg, sweep_item_next;
    logic [SW-1:0]          clr_reg, clr_next;
    logic signed [RC_W:0]   lo_reg, lo_next;
    logic signed [RC_W:0]   hi_reg, hi_next;
    logic [RA_W-1:0]        mid_reg, mid_next;
    logic [AW-1:0]          addr_reg, addr_next;
    logic [AW-1:0]          word_reg, word_next;
    logic [AW-1:0]          bytes_reg, bytes_next;
    logic [31:0]            h_reg, h_next;
    logic [4:0]             step_reg, step_next;
    logic [31:0]            quot_reg, quot_next;
    logic [SW-1:0]          idx_reg, idx_next;
    logic                   ioff_reg, ioff_next;

    logic                   mv_reg, mv_next;
    logic [CW-1:0]          mtot_reg, mtot_next;
    logic [CW-1:0]          moff_reg, moff_next;
    logic                   mcap_reg, mcap_next;
    logic [CC_W-1:0]        mcls_reg, mcls_next;
    logic                   mioff_reg, mioff_next;
    logic [1:0]             mscore_reg, mscore_next;

    logic                   r_we;
    logic [RA_W-1:0]        r_raddr;
    logic [2*AW-1:0]        r_rdata;
    logic                   c_we;
    logic [SW-1:0]          c_waddr;
    logic [AW-1:0]          c_wdata;
    logic [AW-1:0]          c_rdata;

    logic                   in_xfer;
    logic                   out_free;
    logic                   cls_full;
    logic signed [RC_W+1:0] lh_sum;
    logic [RA_W-1:0]        mid_calc;
    logic signed [RC_W:0]   mid_ext;
    logic [95:0]            mod_prod;
    logic [31:0]            mod_rem;
    logic [SW-1:0]          idx_inc;

    assign in_xfer  = s_valid && s_ready;
    assign out_free = !mv_reg || m_ready;
    assign cls_full = ccount_reg >= CC_W'(SET_ENTRIES / 2);
    assign lh_sum   = {lo_reg[RC_W], lo_reg} + {hi_reg[RC_W], hi_reg};
    assign mid_calc = lh_sum[RA_W:1];
    assign mid_ext  = signed'({{(RC_W + 1 - RA_W){1'b0}}, mid_reg});
    assign mod_prod = 96'(h_reg) * 96'(MOD_MAGIC);
    assign mod_rem  = h_reg - quot_reg * 32'(SET_ENTRIES);
    assign idx_inc  = (idx_reg == SW'(SET_ENTRIES - 1)) ? '0 : idx_reg + 1'b1;

    assign r_we    = in_xfer && s_mode == rca_pkg::MODE_RANGE && s_range_end > s_range_start
                     && rcount_reg < RC_W'(RANGE_ENTRIES);
    assign r_raddr = mid_calc;
    assign c_we    = state_reg == ST_SWEEP
                     || (state_reg == ST_P_CMP && c_rdata != word_reg && c_rdata == '0);
    assign c_waddr = state_reg == ST_SWEEP ? clr_reg : idx_reg;
    assign c_wdata = state_reg == ST_SWEEP ? '0 : word_reg;

    rca_ram #(.WIDTH(2 * AW), .DEPTH(RANGE_ENTRIES)) u_range_ram (
        .aclk  (aclk),
        .we    (r_we),
        .waddr (rcount_reg[RA_W-1:0]),
        .wdata ({s_range_end, s_range_start}),
        .raddr (r_raddr),
        .rdata (r_rdata)
    );

    rca_ram #(.WIDTH(AW), .DEPTH(SET_ENTRIES)) u_class_ram (
        .aclk  (aclk),
        .we    (c_we),
        .waddr (c_waddr),
        .wdata (c_wdata),
        .raddr (idx_reg),
        .rdata (c_rdata)
    );

    always_comb begin
        state_next      = state_reg;
        limit_next      = limit_reg;
        thr_next        = thr_reg;
        root_next       = root_reg;
        outside_next    = outside_reg;
        cap_next        = cap_reg;
        ccount_next     = ccount_reg;
        rcount_next     = rcount_reg;
        sweep_item_next = sweep_item_reg;
        clr_next        = clr_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        addr_next       = addr_reg;
        word_next       = word_reg;
        bytes_next      = bytes_reg;
        h_next          = h_reg;
        step_next       = step_reg;
        quot_next       = quot_reg;
        idx_next        = idx_reg;
        ioff_next       = ioff_reg;
        mv_next         = mv_reg;
        mtot_next       = mtot_reg;
        moff_next       = moff_reg;
        mcap_next       = mcap_reg;
        mcls_next       = mcls_reg;
        mioff_next      = mioff_reg;
        mscore_next     = mscore_reg;

        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end

        if (cfg_valid) begin
            if (cfg_index == rca_pkg::REG_VISIT_LIMIT) begin
                limit_next = cfg_data;
            end else if (cfg_index == rca_pkg::REG_ALERT_THR) begin
                thr_next = cfg_data;
            end
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    ioff_next = 1'b0;
                    addr_next = s_object_address;
                    word_next = s_class_word;
                    state_next = ST_DONE;
                    if (s_mode == rca_pkg::MODE_CLEAR) begin
                        root_next    = '0;
                        outside_next = '0;
                        cap_next     = 1'b0;
                        rcount_next  = '0;
                        ccount_next  = '0;
                        if (ccount_reg != '0) begin
                            clr_next        = '0;
                            sweep_item_next = 1'b1;
                            state_next      = ST_SWEEP;
                        end
                    end else if (s_mode == rca_pkg::MODE_RANGE) begin
                        if (r_we) begin
                            rcount_next = rcount_reg + 1'b1;
                        end
                    end else if (s_mode == rca_pkg::MODE_VISIT) begin
                        if (root_reg >= limit_reg) begin
                            cap_next = 1'b1;
                        end else begin
                            root_next = root_reg + 1'b1;
                            if (s_object_address != '0) begin
                                lo_next    = '0;
                                hi_next    = signed'({1'b0, rcount_reg}) - 2'sd1;
                                state_next = ST_S_RD;
                            end
                        end
                    end
                end
            end
            ST_SWEEP: begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == SW'(SET_ENTRIES - 1)) begin
                    state_next = sweep_item_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_S_RD: begin
                if (lo_reg <= hi_reg) begin
                    mid_next   = mid_calc;
                    state_next = ST_S_CMP;
                end else begin
                    outside_next = outside_reg + 1'b1;
                    ioff_next    = 1'b1;
                    h_next       = rca_pkg::FNV_BASIS;
                    bytes_next   = word_reg;
                    step_next    = '0;
                    state_next   = (word_reg == '0 || cls_full) ? ST_DONE : ST_HASH;
                end
            end
            ST_S_CMP: begin
                if (addr_reg < r_rdata[AW-1:0]) begin
                    hi_next    = mid_ext - 2'sd1;
                    state_next = ST_S_RD;
                end else if (addr_reg >= r_rdata[2*AW-1:AW]) begin
                    lo_next    = mid_ext + 2'sd1;
                    state_next = ST_S_RD;
                end else begin
                    h_next     = rca_pkg::FNV_BASIS;
                    bytes_next = word_reg;
                    step_next  = '0;
                    state_next = (word_reg == '0 || cls_full) ? ST_DONE : ST_HASH;
                end
            end
            ST_HASH: begin
                h_next     = 32'((h_reg ^ {24'd0, bytes_reg[7:0]}) * rca_pkg::FNV_PRIME);
                bytes_next = bytes_reg >> 8;
                step_next  = step_reg + 1'b1;
                if (step_reg == 5'd7) begin
                    step_next = '0;
                    if (SET_POW2) begin
                        idx_next   = h_next[SW-1:0];
                        state_next = ST_P_RD;
                    end else begin
                        state_next = ST_MOD;
                    end
                end
            end
            ST_MOD: begin
                if (step_reg == '0) begin
                    quot_next = mod_prod[32 + SW +: 32];
                    step_next = 5'd1;
                end else begin
                    idx_next   = mod_rem[SW-1:0];
                    step_next  = '0;
                    state_next = ST_P_RD;
                end
            end
            ST_P_RD: begin
                state_next = ST_P_CMP;
            end
            ST_P_CMP: begin
                if (c_rdata == word_reg) begin
                    state_next = ST_DONE;
                end else if (c_rdata == '0) begin
                    ccount_next = ccount_reg + 1'b1;
                    state_next  = ST_DONE;
                end else begin
                    idx_next   = idx_inc;
                    state_next = ST_P_RD;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    mv_next     = 1'b1;
                    mtot_next   = root_reg;
                    moff_next   = outside_reg;
                    mcap_next   = cap_reg;
                    mcls_next   = ccount_reg;
                    mioff_next  = ioff_reg;
                    mscore_next = {1'b0, outside_reg != '0} + {1'b0, root_reg > thr_reg};
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_SWEEP;
            limit_reg      <= rca_pkg::VISIT_LIMIT_RST;
            thr_reg        <= rca_pkg::ALERT_THR_RST;
            root_reg       <= '0;
            outside_reg    <= '0;
            cap_reg        <= 1'b0;
            ccount_reg     <= '0;
            rcount_reg     <= '0;
            sweep_item_reg <= 1'b0;
            clr_reg        <= '0;
            mv_reg         <= 1'b0;
        end else begin
            state_reg      <= state_next;
            limit_reg      <= limit_next;
            thr_reg        <= thr_next;
            root_reg       <= root_next;
            outside_reg    <= outside_next;
            cap_reg        <= cap_next;
            ccount_reg     <= ccount_next;
            rcount_reg     <= rcount_next;
            sweep_item_reg <= sweep_item_next;
            clr_reg        <= clr_next;
            mv_reg         <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        addr_reg   <= addr_next;
        word_reg   <= word_next;
        bytes_reg  <= bytes_next;
        h_reg      <= h_next;
        step_reg   <= step_next;
        quot_reg   <= quot_next;
        idx_reg    <= idx_next;
        ioff_reg   <= ioff_next;
        mtot_reg   <= mtot_next;
        moff_reg   <= moff_next;
        mcap_reg   <= mcap_next;
        mcls_reg   <= mcls_next;
        mioff_reg  <= mioff_next;
        mscore_reg <= mscore_next;
    end

    assign s_ready            = state_reg == ST_IDLE;
    assign cfg_ready          = 1'b1;
    assign m_valid            = mv_reg;
    assign m_total_roots      = mtot_reg;
    assign m_offheap_roots    = moff_reg;
    assign m_capped           = mcap_reg;
    assign m_distinct_classes = rca_pkg::CLASS_W'(mcls_reg);
    assign m_item_offheap     = mioff_reg;
    assign m_score            = mscore_reg;

`ifndef SYNTH
    a_set_half: assert property (@(posedge aclk) disable iff (!aresetn)
        ccount_reg <= CC_W'(SET_ENTRIES / 2))
        else $error("class count above half of set");

    a_range_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        rcount_reg <= RC_W'(RANGE_ENTRIES))
        else $error("range count above table depth");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> !s_ready)
        else $error("second transfer taken while busy");

    a_cls_write: assert property (@(posedge aclk) disable iff (!aresetn)
        c_we |-> (state_reg == ST_SWEEP || state_reg == ST_P_CMP))
        else $error("class RAM write outside sweep or probe");
`endif

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for root_range_check_and_class_set: directed and random
// clears, range loads and root visits under random idling on both channels,
// checked transfer by transfer against an in-bench predictor of the counters,
// the range search and the class set.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANGES = rca_pkg::RANGE_ENTRIES_DEF;
    localparam int SLOTS  = rca_pkg::SET_ENTRIES_DEF;
    localparam int AW     = rca_pkg::ADDR_W;
    localparam int CW     = rca_pkg::CNT_W;
    localparam int IW     = rca_pkg::CFG_IDX_W;
    localparam logic [1:0] MODE_NOP = 2'd3;

    typedef struct {
        logic [1:0]    mode;
        logic [AW-1:0] rs, re, oa, cw;
    } root_item_t;

    typedef struct {
        logic [CW-1:0]               total, offheap;
        logic                        capped;
        logic [rca_pkg::CLASS_W-1:0] classes;
        logic                        item_off;
        logic [1:0]                  score;
    } audit_t;

    logic aclk = 0, aresetn = 0;
    logic s_valid = 0, s_ready;
    logic [1:0] s_mode = 0;
    logic [AW-1:0] s_range_start = 0, s_range_end = 0;
    logic [AW-1:0] s_object_address = 0, s_class_word = 0;
    logic m_valid, m_ready = 0;
    logic [CW-1:0] m_total_roots, m_offheap_roots;
    logic m_capped;
    logic [rca_pkg::CLASS_W-1:0] m_distinct_classes;
    logic m_item_offheap;
    logic [1:0] m_score;
    logic cfg_valid = 0, cfg_ready;
    logic [IW-1:0] cfg_index = 0;
    logic [CW-1:0] cfg_data = 0;

    root_range_check_and_class_set dut (.*);

    // predictor state
    logic [AW-1:0] lo_tab [RANGES];
    logic [AW-1:0] hi_tab [RANGES];
    logic [AW-1:0] slots [SLOTS];
    int range_cnt, class_cnt, roots, outside, cap, limit_reg, alert_reg;

    audit_t audit_q[$];
    int n_items, n_results, n_fail, n_capped, n_offheap;
    bit tx_burst, rx_burst;
    int rx_hold;
    logic [AW-1:0] class_pool [16];

    initial forever #2 aclk = ~aclk;

    initial begin
        #40ms;
        $display("root_range_check_and_class_set: mismatch");
        $finish;
    end

    function automatic logic [AW-1:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    function automatic int class_hash(logic [AW-1:0] w);
        logic [31:0] h;
        h = rca_pkg::FNV_BASIS;
        for (int i = 0; i < 8; i++) begin
            h = (h ^ {24'd0, w[8*i +: 8]}) * rca_pkg::FNV_PRIME;
        end
        return int'(h % SLOTS);
    endfunction

    function automatic bit address_covered(logic [AW-1:0] a);
        int lo, hi, mid;
        lo = 0;
        hi = range_cnt - 1;
        while (lo <= hi) begin
            mid = (lo + hi) / 2;
            if (a < lo_tab[mid]) hi = mid - 1;
            else if (a >= hi_tab[mid]) lo = mid + 1;
            else return 1;
        end
        return 0;
    endfunction

    function automatic void class_insert(logic [AW-1:0] w);
        int idx;
        if (w == 0 || class_cnt >= SLOTS / 2) return;
        idx = class_hash(w);
        for (int i = 0; i < SLOTS; i++) begin
            if (slots[idx] == w) return;
            if (slots[idx] == 0) begin
                slots[idx] = w;
                class_cnt++;
                return;
            end
            idx = (idx + 1) % SLOTS;
        end
    endfunction

    function automatic void wipe_audit();
        range_cnt = 0;
        class_cnt = 0;
        roots = 0;
        outside = 0;
        cap = 0;
        foreach (slots[i]) slots[i] = 0;
    endfunction

    function automatic void predict_audit(root_item_t it);
        audit_t r;
        r.item_off = 1'b0;
        case (it.mode)
            rca_pkg::MODE_CLEAR: wipe_audit();
            rca_pkg::MODE_RANGE: begin
                if (it.re > it.rs && range_cnt < RANGES) begin
                    lo_tab[range_cnt] = it.rs;
                    hi_tab[range_cnt] = it.re;
                    range_cnt++;
                end
            end
            rca_pkg::MODE_VISIT: begin
                if (roots >= limit_reg) begin
                    cap = 1;
                end else begin
                    roots = (roots + 1) & 'h1FFFF;
                    if (it.oa != 0) begin
                        if (!address_covered(it.oa)) begin
                            outside = (outside + 1) & 'h1FFFF;
                            r.item_off = 1'b1;
                        end
                        class_insert(it.cw);
                    end
                end
            end
            default: ;
        endcase
        r.total   = CW'(roots);
        r.offheap = CW'(outside);
        r.capped  = cap[0];
        r.classes = rca_pkg::CLASS_W'(class_cnt);
        r.score   = {1'b0, outside > 0} + {1'b0, roots > alert_reg};
        audit_q.push_back(r);
    endfunction

    task automatic push_item(root_item_t it);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            s_valid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_valid          <= 1;
        s_mode           <= it.mode;
        s_range_start    <= it.rs;
        s_range_end      <= it.re;
        s_object_address <= it.oa;
        s_class_word     <= it.cw;
        do @(posedge aclk); while (!s_ready);
        n_items++;
        predict_audit(it);
    endtask

    task automatic send(logic [1:0] mode, logic [AW-1:0] x, logic [AW-1:0] y);
        root_item_t it;
        it.mode = mode;
        it.rs = rnd64();
        it.re = rnd64();
        it.oa = rnd64();
        it.cw = rnd64();
        if (mode == rca_pkg::MODE_RANGE) begin
            it.rs = x;
            it.re = y;
        end else if (mode == rca_pkg::MODE_VISIT) begin
            it.oa = x;
            it.cw = y;
        end
        push_item(it);
    endtask

    task automatic drain();
        s_valid <= 0;
        while (audit_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(logic [IW-1:0] idx, int value);
        drain();
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= value[CW-1:0];
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 0;
        if (idx == rca_pkg::REG_VISIT_LIMIT) limit_reg = value & 'h1FFFF;
        else if (idx == rca_pkg::REG_ALERT_THR) alert_reg = value & 'h1FFFF;
    endtask

    function automatic logic [AW-1:0] pick_class();
        case ($urandom_range(0, 5))
            0: return 0;
            1, 2: return rnd64();
            default: return class_pool[$urandom_range(0, 15)];
        endcase
    endfunction

    function automatic logic [AW-1:0] pick_address();
        int k;
        if (range_cnt > 0 && $urandom_range(0, 2) != 0) begin
            k = $urandom_range(0, range_cnt - 1);
            case ($urandom_range(0, 3))
                0: return lo_tab[k];
                1: return hi_tab[k] - 1;
                2: return hi_tab[k];
                default: return lo_tab[k] + ((hi_tab[k] - lo_tab[k]) >> 1);
            endcase
        end
        if ($urandom_range(0, 9) == 0) return 0;
        return rnd64();
    endfunction

    task automatic load_sorted_ranges(int count);
        logic [AW-1:0] base, len;
        base = {4'h0, $urandom, 28'($urandom_range(0, 'hFFFFFFF))};
        for (int i = 0; i < count; i++) begin
            base = base + AW'($urandom_range(0, 4096));
            len  = AW'($urandom_range(1, 65536));
            send(rca_pkg::MODE_RANGE, base, base + len);
            base = base + len;
        end
    endtask

    task automatic test_directed_cases();
        send(MODE_NOP, 0, 0);
        send(rca_pkg::MODE_VISIT, 0, rnd64());
        send(rca_pkg::MODE_VISIT, 64'd1, 64'd0);
        send(rca_pkg::MODE_VISIT, '1, '1);
        send(rca_pkg::MODE_VISIT, '1, '1);
        send(rca_pkg::MODE_RANGE, 64'd100, 64'd100);
        send(rca_pkg::MODE_RANGE, 64'd200, 64'd100);
        send(rca_pkg::MODE_RANGE, 64'd0, 64'd1000);
        send(rca_pkg::MODE_RANGE, 64'd5000, '1);
        send(rca_pkg::MODE_VISIT, 64'd999, 64'd5);
        send(rca_pkg::MODE_VISIT, 64'd1000, 64'd5);
        send(rca_pkg::MODE_VISIT, 64'd5000, 64'h8000_0000_0000_0000);
        send(rca_pkg::MODE_VISIT, 64'hFFFF_FFFF_FFFF_FFFE, 64'h00FF_00FF_00FF_00FF);
        send(rca_pkg::MODE_VISIT, '1, 64'hFF00_FF00_FF00_FF00);
        send(MODE_NOP, '1, '1);
        send(rca_pkg::MODE_RANGE, 64'd20, 64'd30);
        send(rca_pkg::MODE_VISIT, 64'd25, 64'd7);
        send(rca_pkg::MODE_CLEAR, 0, 0);
        send(rca_pkg::MODE_VISIT, 64'd25, 64'd7);
    endtask

    task automatic test_register_extremes();
        write_reg(rca_pkg::REG_VISIT_LIMIT, 1);
        write_reg(rca_pkg::REG_ALERT_THR, 0);
        send(rca_pkg::MODE_CLEAR, 0, 0);
        repeat (3) send(rca_pkg::MODE_VISIT, rnd64(), rnd64());
        write_reg(rca_pkg::REG_VISIT_LIMIT, 0);
        send(rca_pkg::MODE_CLEAR, 0, 0);
        repeat (2) send(rca_pkg::MODE_VISIT, rnd64(), rnd64());
        write_reg(rca_pkg::REG_VISIT_LIMIT, 65536);
        write_reg(rca_pkg::REG_ALERT_THR, 65536);
        repeat (3) send(rca_pkg::MODE_VISIT, rnd64(), rnd64());
        write_reg(rca_pkg::REG_ALERT_THR, 3);
        repeat (3) send(rca_pkg::MODE_VISIT, 0, 0);
    endtask

    task automatic test_range_table_full();
        send(rca_pkg::MODE_CLEAR, 0, 0);
        tx_burst = 1;
        load_sorted_ranges(RANGES + 4);
        tx_burst = 0;
        repeat (40) send(rca_pkg::MODE_VISIT, pick_address(), pick_class());
        send(rca_pkg::MODE_CLEAR, 0, 0);
        send(rca_pkg::MODE_RANGE, 64'd5000, 64'd6000);
        send(rca_pkg::MODE_RANGE, 64'd1000, 64'd2000);
        send(rca_pkg::MODE_RANGE, 64'd3000, 64'd4000);
        send(rca_pkg::MODE_VISIT, 64'd1500, 64'd1);
        send(rca_pkg::MODE_VISIT, 64'd3500, 64'd2);
        send(rca_pkg::MODE_VISIT, 64'd5500, 64'd3);
    endtask

    task automatic test_set_half_full();
        send(rca_pkg::MODE_CLEAR, 0, 0);
        tx_burst = 1;
        rx_burst = 1;
        for (int i = 0; i < SLOTS / 2 + 8; i++) begin
            send(rca_pkg::MODE_VISIT, rnd64() | 64'd1, rnd64() | 64'd1);
        end
        tx_burst = 0;
        rx_burst = 0;
        repeat (5) send(rca_pkg::MODE_VISIT, rnd64() | 64'd1, pick_class());
    endtask

    task automatic test_output_backpressure();
        drain();
        rx_hold = 400;
        repeat (30) send(rca_pkg::MODE_VISIT, pick_address(), pick_class());
    endtask

    task automatic test_random_sessions();
        int sent, visits;
        sent = 0;
        while (sent < 250) begin
            case ($urandom_range(0, 3))
                0: write_reg(rca_pkg::REG_VISIT_LIMIT, $urandom_range(1, 60));
                1: write_reg(rca_pkg::REG_VISIT_LIMIT, $urandom_range(0, 65536));
                default: write_reg(rca_pkg::REG_VISIT_LIMIT, 65536);
            endcase
            write_reg(rca_pkg::REG_ALERT_THR, $urandom_range(0, 3) == 0 ?
                      $urandom_range(0, 65536) : $urandom_range(0, 50));
            tx_burst = ($urandom_range(0, 3) == 0);
            rx_burst = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 4) != 0) begin
                send(rca_pkg::MODE_CLEAR, 0, 0);
                sent++;
            end
            visits = $urandom_range(0, 7) == 0 ? 200 : $urandom_range(0, 12);
            load_sorted_ranges(visits);
            sent += visits;
            visits = $urandom_range(20, 60);
            for (int i = 0; i < visits; i++) begin
                case ($urandom_range(0, 19))
                    0: send(MODE_NOP, rnd64(), rnd64());
                    1: send(rca_pkg::MODE_RANGE, rnd64(), rnd64());
                    2: send(rca_pkg::MODE_CLEAR, 0, 0);
                    default: send(rca_pkg::MODE_VISIT, pick_address(), pick_class());
                endcase
            end
            sent += visits;
        end
        tx_burst = 0;
        rx_burst = 0;
    endtask

    initial begin
        int stall;
        @(posedge aclk iff aresetn);
        forever begin
            if (rx_hold > 0) begin
                stall = rx_hold;
                rx_hold = 0;
            end else begin
                stall = rx_burst ? 0 : $urandom_range(0, 18);
            end
            if (stall > 0) begin
                m_ready <= 0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1;
            do @(posedge aclk); while (!m_valid);
            n_results++;
            if (m_capped) n_capped++;
            if (m_item_offheap) n_offheap++;
            if (audit_q.size() == 0) begin
                $error("result transfer with nothing expected");
                n_fail++;
            end else begin
                audit_t e;
                e = audit_q.pop_front();
                if (m_total_roots !== e.total) begin
                    $error("total_roots exp %0d got %0d", e.total, m_total_roots);
                    n_fail++;
                end
                if (m_offheap_roots !== e.offheap) begin
                    $error("offheap_roots exp %0d got %0d", e.offheap, m_offheap_roots);
                    n_fail++;
                end
                if (m_capped !== e.capped) begin
                    $error("capped exp %0d got %0d", e.capped, m_capped);
                    n_fail++;
                end
                if (m_distinct_classes !== e.classes) begin
                    $error("distinct_classes exp %0d got %0d", e.classes,
                           m_distinct_classes);
                    n_fail++;
                end
                if (m_item_offheap !== e.item_off) begin
                    $error("item_offheap exp %0d got %0d", e.item_off, m_item_offheap);
                    n_fail++;
                end
                if (m_score !== e.score) begin
                    $error("score exp %0d got %0d", e.score, m_score);
                    n_fail++;
                end
            end
        end
    end

    initial begin
        foreach (lo_tab[i]) begin
            lo_tab[i] = 0;
            hi_tab[i] = 0;
        end
        wipe_audit();
        limit_reg = int'(rca_pkg::VISIT_LIMIT_RST);
        alert_reg = int'(rca_pkg::ALERT_THR_RST);
        foreach (class_pool[i]) class_pool[i] = rnd64();
        repeat (11) @(posedge aclk);
        aresetn <= 1;
        test_directed_cases();
        test_register_extremes();
        test_range_table_full();
        test_set_half_full();
        test_output_backpressure();
        test_random_sessions();
        drain();
        repeat (200) @(posedge aclk);
        if (audit_q.size() != 0) begin
            $error("%0d results never arrived", audit_q.size());
            n_fail++;
        end
        $display("Sent %0d items (clears, range loads, visits, no-ops); checked %0d results.",
                 n_items, n_results);
        $display("Results with capped set: %0d, off-heap visits: %0d.", n_capped, n_offheap);
        if (n_fail == 0) begin
            $display("root_range_check_and_class_set: match");
        end else begin
            $display("root_range_check_and_class_set: mismatch");
        end
        $finish;
    end
endmodule
